// ===== rtl/tac_pkg.sv =====
// ----------------------------------------------------------------------------
// tac_pkg
// Types, constants and elaboration-time functions of the thermistor converter.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int ADC_W     = 16;
  localparam int T0_W      = 8;
  localparam int OHM_W     = 24;
  localparam int BETA_W    = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 16;
  localparam int ST_W      = 2;

  // log2 datapath
  localparam int LOGQ   = 16;
  localparam int X_W    = 57;   // widest log2 operand (divider denominator)
  localparam int E_W    = 6;
  localparam int F_W    = 31;
  localparam int ENT_W  = 17;   // table entry, up to exactly 1.0 in Q16
  localparam int LOG_W  = 23;
  localparam int LSUM_W = 25;
  localparam int MUL_W  = 56;
  localparam int D_W    = 45;
  localparam int REM_W  = 44;
  localparam int BK_W   = 23;   // beta * 100
  localparam int BT0_W  = 43;   // beta * 100 * 2^32 / T0 in centikelvin

  localparam int DIV_STEPS = 16;
  localparam int CDIV_BITS = 55;
  localparam int CDIV_CNT_W = 6;

  // operand slots of the log2 lanes
  localparam int OP_R2  = 0;
  localparam int OP_VA  = 1;
  localparam int OP_DEN = 2;
  localparam int OP_R0  = 3;
  localparam int OP_R1  = 4;
  localparam int NOPS   = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_FS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_T  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_R  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULLUP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_OPEN  = 2'd1;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd2;

  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 16'sd32767;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -16'sd27315;
  localparam logic [16:0] KELVIN_CENTI = 17'd27315;
  localparam logic [15:0] TCK_MAX      = 16'd60082;
  localparam logic signed [30:0] LN2_Q30 = 31'sd744261118;

  // reset values
  localparam logic [ADC_W-1:0]         RST_ADC_FS = 16'd1023;
  localparam logic signed [T0_W-1:0]   RST_NOM_T  = 8'sd25;
  localparam logic [OHM_W-1:0]         RST_NOM_R  = 24'd100000;
  localparam logic [BETA_W-1:0]        RST_BETA   = 16'd3950;
  localparam logic [OHM_W-1:0]         RST_PULLUP = 24'd0;
  localparam logic [OHM_W-1:0]         RST_SERIES = 24'd4700;
  localparam logic [BT0_W-1:0]         BT0_RST    =
    BT0_W'(((64'd3950 * 64'd100) << 32) / 64'd29815);

  typedef struct packed {
    logic [E_W-1:0] e;
    logic [F_W-1:0] f;
  } norm_t;

  typedef struct packed {
    logic                     sp;
    logic signed [TEMP_W-1:0] temp;
    logic [ST_W-1:0]          st;
  } side_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [ST_W-1:0]          status;
  } res_t;

  // leading-one position and the bits below it, left aligned
  function automatic norm_t log_norm(logic [X_W-1:0] x);
    norm_t r;
    logic [X_W+F_W-1:0] y;
    r.e = '0;
    for (int b = 0; b < X_W; b++) begin
      if (x[b]) r.e = E_W'(b);
    end
    y   = {x, {F_W{1'b0}}} >> r.e;
    r.f = y[F_W-1:0];
    return r;
  endfunction

  // log2(1 + i / 2^bits) in Q16 by repeated squaring, last entry exactly 1.0
  function automatic logic [ENT_W-1:0] log_entry(int unsigned i, int unsigned bits);
    logic [63:0] y;
    logic [ENT_W-1:0] res;
    y   = (64'd1 << 30) + (64'(i) << (30 - bits));
    res = '0;
    for (int k = LOGQ - 1; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        res[k] = 1'b1;
        y = y >> 1;
      end
    end
    if (i == (32'd1 << bits)) res = ENT_W'(32'd1 << LOGQ);
    return res;
  endfunction

endpackage

// ===== rtl/tac_if.sv =====
// ----------------------------------------------------------------------------
// tac_if
// Valid/ready channels of the thermistor converter: samples in, results out.
// ----------------------------------------------------------------------------
interface tac_in_if;
  logic                       valid;
  logic                       ready;
  logic [tac_pkg::ADC_W-1:0]  adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tac_pkg::TEMP_W-1:0] temp_centi_c;
  logic [tac_pkg::ST_W-1:0]          status;
  modport source (output valid, output temp_centi_c, output status, input ready);
  modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

// ===== rtl/thermistor_adc_to_celsius_top.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius_top
// NTC thermistor beta equation: ADC sample in, hundredths of a degree out.
// ----------------------------------------------------------------------------
// Path: an input request passes 29 stages and a two-entry output buffer.
// Throughput: one request per cycle while the output buffer has room; a write
//   of the nominal temperature or beta holds off input while the serial
//   divider forms beta/T0.
// Reset: all valid bits and the output buffer empty, registers at their
//   defaults, beta/T0 preloaded with its default value.
// ----------------------------------------------------------------------------
module thermistor_adc_to_celsius_top #(
  parameter int ADC_REF_MV     = 5000,
  parameter int BIAS_SUPPLY_MV = 5000,
  parameter int LN_TABLE_BITS  = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tac_in_if.sink                          in_if,
  tac_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [tac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tac_pkg::CFG_W-1:0]       cfg_data_i
);
  import tac_pkg::*;

  localparam int TBL_N  = (1 << LN_TABLE_BITS) + 1;
  localparam int SPAN   = F_W - LN_TABLE_BITS;
  localparam int IDX_W  = LN_TABLE_BITS + 1;
  localparam int PROD_W = SPAN + ENT_W;
  localparam logic [15:0] REF_MV  = 16'(ADC_REF_MV);
  localparam logic [15:0] BIAS_MV = 16'(BIAS_SUPPLY_MV);

  // stage numbering
  localparam int S_IN   = 0;   // sample register
  localparam int S_MUL1 = 1;   // va, r1*Vcc, r1+r2, F+1
  localparam int S_MUL2 = 2;   // p and q of the divider
  localparam int S_DEN  = 3;   // denominator, open-circuit test
  localparam int S_NORM = 4;   // leading-one normalise, five lanes
  localparam int S_LUT  = 5;   // table read
  localparam int S_INTP = 6;   // interpolation product
  localparam int S_LOG  = 7;   // assemble log2 values
  localparam int S_SUM  = 8;   // log ratio sum
  localparam int S_LN2  = 9;   // times ln2
  localparam int S_D    = 10;  // add beta/T0
  localparam int S_CHK  = 11;  // sign and overflow test, divider seed
  localparam int S_OUT  = S_CHK + DIV_STEPS + 1;
  localparam int NSTG   = S_OUT + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0]       cfg_fs_q;
  logic signed [T0_W-1:0] cfg_t0_q;
  logic [OHM_W-1:0]       cfg_r0_q;
  logic [BETA_W-1:0]      cfg_beta_q;
  logic [OHM_W-1:0]       cfg_r1_q;
  logic [OHM_W-1:0]       cfg_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fs_q   <= RST_ADC_FS;
      cfg_t0_q   <= RST_NOM_T;
      cfg_r0_q   <= RST_NOM_R;
      cfg_beta_q <= RST_BETA;
      cfg_r1_q   <= RST_PULLUP;
      cfg_r2_q   <= RST_SERIES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADC_FS: cfg_fs_q   <= cfg_data_i[ADC_W-1:0];
        CFG_NOM_T:  cfg_t0_q   <= cfg_data_i[T0_W-1:0];
        CFG_NOM_R:  cfg_r0_q   <= cfg_data_i[OHM_W-1:0];
        CFG_BETA:   cfg_beta_q <= cfg_data_i[BETA_W-1:0];
        CFG_PULLUP: cfg_r1_q   <= cfg_data_i[OHM_W-1:0];
        CFG_SERIES: cfg_r2_q   <= cfg_data_i[OHM_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Serial divider for beta*100*2^32 / T0c, one quotient bit per cycle.
  // It depends on registers only, so it runs once after the relevant write.
  // --------------------------------------------------------------------------
  logic [BK_W-1:0]       bk;
  logic signed [16:0]    t0c_s;
  logic [15:0]           t0c;
  logic [CDIV_BITS-1:0]  cdiv_num;
  logic                  cdiv_bit;
  logic [17:0]           cdiv_try;
  logic                  cdiv_ge;
  logic [15:0]           cdiv_rem_d;
  logic [BT0_W-1:0]      cdiv_quo_d;

  logic                  cdiv_busy_q;
  logic [CDIV_CNT_W-1:0] cdiv_step_q;
  logic [15:0]           cdiv_rem_q;
  logic [BT0_W-1:0]      cdiv_quo_q;
  logic [BT0_W-1:0]      bt0_q;

  assign bk       = BK_W'(cfg_beta_q) * BK_W'(100);
  assign t0c_s    = 17'(cfg_t0_q) * 17'sd100 + 17'sd27315;
  assign t0c      = t0c_s[15:0];
  assign cdiv_num = {bk, 32'b0};
  assign cdiv_bit = cdiv_num[CDIV_CNT_W'(CDIV_BITS - 1) - cdiv_step_q];
  assign cdiv_try = {1'b0, cdiv_rem_q, cdiv_bit} - {2'b00, t0c};
  assign cdiv_ge  = !cdiv_try[17];
  // the partial remainder stays below T0c, so 16 bits always hold it
  assign cdiv_rem_d = cdiv_ge ? cdiv_try[15:0] : {cdiv_rem_q[14:0], cdiv_bit};
  assign cdiv_quo_d = {cdiv_quo_q[BT0_W-2:0], cdiv_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cdiv_busy_q <= 1'b0;
      cdiv_step_q <= '0;
      cdiv_rem_q  <= '0;
      cdiv_quo_q  <= '0;
      bt0_q       <= BT0_RST;
    end else if (cfg_we_i && (cfg_idx_i == CFG_NOM_T || cfg_idx_i == CFG_BETA)) begin
      // restart on the new register values, seen from the next cycle on
      cdiv_busy_q <= 1'b1;
      cdiv_step_q <= '0;
      cdiv_rem_q  <= '0;
      cdiv_quo_q  <= '0;
    end else if (cdiv_busy_q) begin
      cdiv_rem_q  <= cdiv_rem_d;
      cdiv_quo_q  <= cdiv_quo_d;
      cdiv_step_q <= cdiv_step_q + 1'b1;
      if (cdiv_step_q == CDIV_CNT_W'(CDIV_BITS - 1)) begin
        cdiv_busy_q <= 1'b0;
        bt0_q       <= cdiv_quo_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Log2 table, constant
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0] log_tbl [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    assign log_tbl[g] = log_entry(g, LN_TABLE_BITS);
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together while the output buffer
  // has room; valid bits travel with the data.
  // --------------------------------------------------------------------------
  logic              adv;
  logic              in_acc;
  logic [NSTG-1:0]   vld_q;
  logic [1:0]        fifo_cnt_q;

  assign adv         = (fifo_cnt_q != 2'd2);
  assign in_if.ready = adv && !cdiv_busy_q;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_acc};
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0]  adc_q;
  logic [31:0]       va1_q, va2_q, va3_q;
  logic [39:0]       m1_q;
  logic [24:0]       r12_q;
  logic [16:0]       f1_q;
  logic [X_W-1:0]    p2_q, q2_q, den3_q;
  norm_t             nrm_q [NOPS];
  logic [ENT_W-1:0]  a5_q  [NOPS];
  logic [ENT_W-1:0]  df5_q [NOPS];
  logic [SPAN-1:0]   rm5_q [NOPS];
  logic [E_W-1:0]    e5_q  [NOPS];
  logic [ENT_W-1:0]  a6_q  [NOPS];
  logic [ENT_W-1:0]  ph6_q [NOPS];
  logic [E_W-1:0]    e6_q  [NOPS];
  logic [LOG_W-1:0]  lg7_q [NOPS];
  logic signed [LSUM_W-1:0] lsum8_q;
  logic signed [MUL_W-1:0]  mult9_q;
  logic signed [D_W-1:0]    d10_q;
  // index 0 is the seed stage, index j+1 the result of division step j
  logic [REM_W-1:0]     dv_rem_q [DIV_STEPS+1];
  logic [REM_W-1:0]     dv_d_q   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dv_quo_q [DIV_STEPS+1];
  side_t             side_q [NSTG];
  res_t              res_q;

  // next values
  logic [31:0]       va1_d;
  logic [39:0]       m1_d;
  logic [24:0]       r12_d;
  logic [16:0]       f1_d;
  logic [X_W-1:0]    p2_d, q2_d, den3_d;
  logic              short_w, open_w;
  logic [OHM_W-1:0]  r0_eff;
  logic [X_W-1:0]    op_x   [NOPS];
  norm_t             nrm_d  [NOPS];
  logic [IDX_W-1:0]  lut_ia [NOPS];
  logic [IDX_W-1:0]  lut_ib [NOPS];
  logic [ENT_W-1:0]  lut_a  [NOPS];
  logic [ENT_W-1:0]  lut_b  [NOPS];
  logic [PROD_W-1:0] prod   [NOPS];
  logic [LOG_W-1:0]  lg_d   [NOPS];
  logic [LSUM_W-1:0] r1_term;
  logic signed [LSUM_W-1:0] lsum_d;
  logic signed [MUL_W-1:0]  mult_d;
  logic signed [D_W-1:0]    d_d;
  logic              d_pos, d_ovf;
  logic [REM_W-1:0]  n_hi;
  logic [REM_W:0]    dv_t   [DIV_STEPS];
  logic              dv_ge  [DIV_STEPS];
  logic [REM_W-1:0]  dv_rem_d [DIV_STEPS];
  side_t             side_d [NSTG];
  logic [DIV_STEPS-1:0] tck;
  res_t              res_d;

  // front end: voltages and the divider equation
  always_comb begin
    va1_d   = 32'(adc_q) * 32'(REF_MV);
    m1_d    = (cfg_r1_q != '0) ? 40'(cfg_r1_q) * 40'(BIAS_MV) : 40'(BIAS_MV);
    // without a pull-up the source is the supply itself, so q is va alone
    r12_d   = (cfg_r1_q != '0) ? 25'(cfg_r1_q) + 25'(cfg_r2_q) : 25'd1;
    f1_d    = 17'(cfg_fs_q) + 17'd1;
    short_w = (adc_q == '0) || (cfg_r2_q == '0);
    p2_d    = X_W'(m1_q) * X_W'(f1_q);
    q2_d    = X_W'(va1_q) * X_W'(r12_q);
    open_w  = (q2_q >= p2_q);
    den3_d  = p2_q - q2_q;
  end

  // log2 lanes
  always_comb begin
    r0_eff         = (cfg_r0_q != '0) ? cfg_r0_q : OHM_W'(1);
    op_x[OP_R2]    = X_W'(cfg_r2_q);
    op_x[OP_VA]    = X_W'(va3_q);
    op_x[OP_DEN]   = den3_q;
    op_x[OP_R0]    = X_W'(r0_eff);
    op_x[OP_R1]    = X_W'(cfg_r1_q);
    for (int k = 0; k < NOPS; k++) begin
      nrm_d[k]  = log_norm(op_x[k]);
      lut_ia[k] = IDX_W'(nrm_q[k].f[F_W-1 -: LN_TABLE_BITS]);
      lut_ib[k] = lut_ia[k] + 1'b1;
      lut_a[k]  = log_tbl[lut_ia[k]];
      lut_b[k]  = log_tbl[lut_ib[k]];
      prod[k]   = PROD_W'(df5_q[k]) * PROD_W'(rm5_q[k]);
      lg_d[k]   = LOG_W'({e6_q[k], {LOGQ{1'b0}}}) + LOG_W'(a6_q[k]) + LOG_W'(ph6_q[k]);
    end
  end

  // log ratio, scaling and the sum with beta/T0
  always_comb begin
    r1_term = (cfg_r1_q != '0) ? LSUM_W'(lg7_q[OP_R1]) : '0;
    lsum_d  = $signed(LSUM_W'(lg7_q[OP_R2]) + LSUM_W'(lg7_q[OP_VA]) + r1_term
                      - LSUM_W'(lg7_q[OP_DEN]) - LSUM_W'(lg7_q[OP_R0]));
    mult_d  = lsum8_q * LN2_Q30;
    // arithmetic shift gives the floor of the scaled log
    d_d     = D_W'(mult9_q >>> 14) + $signed({2'b00, bt0_q});
    d_pos   = !d10_q[D_W-1] && (d10_q != '0);
    n_hi    = REM_W'({bk, 16'b0});
    // quotient of 2^16 or more cannot fit the result
    d_ovf   = (n_hi >= REM_W'(d10_q));
  end

  // restoring division steps for Tck = beta*100*2^32 / D
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_t[j]     = {dv_rem_q[j], 1'b0};
      dv_ge[j]    = (dv_t[j] >= {1'b0, dv_d_q[j]});
      dv_rem_d[j] = dv_ge[j] ? REM_W'(dv_t[j] - {1'b0, dv_d_q[j]}) : REM_W'(dv_t[j]);
    end
  end

  // early results ride along with the item and win at the end
  always_comb begin
    side_d[0] = '0;
    for (int i = 1; i < NSTG; i++) side_d[i] = side_q[i-1];
    if (short_w) begin
      side_d[S_MUL1] = '{sp: 1'b1, temp: TEMP_HIGH, st: ST_SHORT};
    end
    if (!side_q[S_DEN-1].sp && open_w) begin
      side_d[S_DEN] = '{sp: 1'b1, temp: TEMP_LOW, st: ST_OPEN};
    end
    if (!side_q[S_CHK-1].sp && (!d_pos || d_ovf)) begin
      side_d[S_CHK] = '{sp: 1'b1, temp: TEMP_HIGH, st: ST_OPEN};
    end
  end

  // final result
  always_comb begin
    tck = dv_quo_q[DIV_STEPS];
    priority if (side_q[S_OUT-1].sp) begin
      res_d.temp   = side_q[S_OUT-1].temp;
      res_d.status = side_q[S_OUT-1].st;
    end else if (tck > TCK_MAX) begin
      res_d.temp   = TEMP_HIGH;
      res_d.status = ST_OPEN;
    end else begin
      res_d.temp   = TEMP_W'(17'(tck) - KELVIN_CENTI);
      res_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adc_q   <= in_if.adc_sample;
      va1_q   <= va1_d;
      m1_q    <= m1_d;
      r12_q   <= r12_d;
      f1_q    <= f1_d;
      p2_q    <= p2_d;
      q2_q    <= q2_d;
      va2_q   <= va1_q;
      den3_q  <= den3_d;
      va3_q   <= va2_q;
      for (int k = 0; k < NOPS; k++) begin
        nrm_q[k] <= nrm_d[k];
        a5_q[k]  <= lut_a[k];
        df5_q[k] <= lut_b[k] - lut_a[k];
        rm5_q[k] <= nrm_q[k].f[SPAN-1:0];
        e5_q[k]  <= nrm_q[k].e;
        a6_q[k]  <= a5_q[k];
        ph6_q[k] <= prod[k][PROD_W-1:SPAN];
        e6_q[k]  <= e5_q[k];
        lg7_q[k] <= lg_d[k];
      end
      lsum8_q     <= lsum_d;
      mult9_q     <= mult_d;
      d10_q       <= d_d;
      dv_rem_q[0] <= n_hi;
      dv_d_q[0]   <= REM_W'(d10_q);
      dv_quo_q[0] <= '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_rem_q[j+1] <= dv_rem_d[j];
        dv_d_q[j+1]   <= dv_d_q[j];
        dv_quo_q[j+1] <= {dv_quo_q[j][DIV_STEPS-2:0], dv_ge[j]};
      end
      for (int i = 0; i < NSTG; i++) side_q[i] <= side_d[i];
      res_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer: parts the pipeline from the output handshake
  // --------------------------------------------------------------------------
  res_t  fifo_q [2];
  logic  fifo_wr_q, fifo_rd_q;
  logic  push, pop;

  assign push = adv && vld_q[S_OUT];
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[fifo_wr_q] <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= 1'b0;
      fifo_rd_q  <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (push) fifo_wr_q <= !fifo_wr_q;
      if (pop)  fifo_rd_q <= !fifo_rd_q;
      fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_if.valid        = (fifo_cnt_q != 2'd0);
  assign out_if.temp_centi_c = fifo_q[fifo_rd_q].temp;
  assign out_if.status       = fifo_q[fifo_rd_q].status;

endmodule
